// ===== rtl/ppe_pkg.sv =====
// Shared types and constants for the pixel pedestal entry encoder.
`timescale 1ns / 1ps
package ppe_pkg;

  localparam int COL_W    = 9;
  localparam int ROW_W    = 9;
  localparam int LEVEL_W  = 16;
  localparam int MULT_W   = 16;
  localparam int OFFSET_W = 20;
  localparam int ENTRY_W  = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_TYPE = 1'b0,
    REG_NOISE_MULT  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    SENSOR_SUBMATRIX = 1'b0,
    SENSOR_QUADRANT  = 1'b1
  } sensor_t;

  typedef struct packed {
    sensor_t             sensor_type;
    logic [MULT_W-1:0]   noise_multiplier;
  } cfg_t;

  localparam logic [MULT_W-1:0]  NOISE_MULT_RESET = 16'd512;
  localparam logic [ENTRY_W-1:0] MASK_WORD        = 12'h81F;

  // Geometry of both sensor types.
  localparam logic [COL_W-1:0] DUMMY_COLS   = 9'd2;
  localparam logic [COL_W-1:0] SMALL_SIZE   = 9'd256;
  localparam logic [COL_W-1:0] QUAD_COLS    = 9'd254;
  localparam logic [COL_W-1:0] QUAD_X_LIMIT = 9'd508;
  localparam logic [7:0]       QUAD_X_LAST  = 8'd253;
  localparam logic [7:0]       QUAD_Y_LAST  = 8'd255;

  // Threshold clamp range.
  localparam int THR_MAX = 31;
  localparam int THR_MIN = -32;

endpackage

// ===== rtl/ppe_cfg_regs.sv =====
// Configuration register file: sensor type and noise multiplier.
`timescale 1ns / 1ps
module ppe_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_enable,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppe_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ppe_pkg::cfg_t                    cfg
);
  import ppe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_type      <= SENSOR_SUBMATRIX;
      cfg.noise_multiplier <= NOISE_MULT_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SENSOR_TYPE: cfg.sensor_type      <= sensor_t'(cfg_data[0]);
        REG_NOISE_MULT:  cfg.noise_multiplier <= cfg_data[MULT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ppe_addr_map.sv =====
// Coordinate to pedestal memory word address mapping for both sensor types.
`timescale 1ns / 1ps
module ppe_addr_map (
  input  ppe_pkg::sensor_t                 sensor_type,
  input  logic [ppe_pkg::COL_W-1:0]        column,
  input  logic [ppe_pkg::ROW_W-1:0]        row,
  output logic [ppe_pkg::OFFSET_W-1:0]     memory_offset,
  output logic                             coordinate_error
);
  import ppe_pkg::*;

  logic [1:0]       s_sub;
  logic [COL_W-1:0] s_col;
  logic [ROW_W-1:0] s_row;
  logic             s_ok;

  logic             q_xhi;
  logic [COL_W-1:0] q_xrel;
  logic [7:0]       q_x;
  logic [7:0]       q_y;
  logic [1:0]       q_sub;
  logic [COL_W-1:0] q_col;
  logic [ROW_W-1:0] q_row;
  logic             q_ok;

  // Submatrix sensor: 64-column submatrices, swap 1 and 2.
  always_comb begin
    s_ok  = (column < SMALL_SIZE) && (row < SMALL_SIZE);
    s_sub = column[7:6];
    if (s_sub == 2'd1 || s_sub == 2'd2) s_sub = ~s_sub;
    s_col = {3'b000, column[5:0]} + DUMMY_COLS;
    s_row = row;
  end

  // Quadrant sensor: four 254x256 quadrants, swap 1 and 3, then mirror.
  always_comb begin
    q_ok   = column < QUAD_X_LIMIT;
    q_xhi  = column >= QUAD_COLS;
    q_xrel = q_xhi ? (column - QUAD_COLS) : column;
    q_x    = q_xrel[7:0];
    q_y    = row[7:0];
    q_sub  = {row[8], q_xhi};
    if (q_sub == 2'd1 || q_sub == 2'd3) q_sub = {~q_sub[1], q_sub[0]};
    unique case (q_sub)
      2'd3: q_x = QUAD_X_LAST - q_x;
      2'd2: q_y = QUAD_Y_LAST - q_y;
      2'd1: begin
        q_x = QUAD_X_LAST - q_x;
        q_y = QUAD_Y_LAST - q_y;
      end
      default: ;
    endcase
    q_col = {1'b0, q_x} + DUMMY_COLS;
    q_row = {1'b0, q_y};
  end

  always_comb begin
    unique case (sensor_type)
      SENSOR_QUADRANT: begin
        coordinate_error = !q_ok;
        memory_offset    = q_ok ? {q_sub, q_row, q_col} : '0;
      end
      default: begin
        coordinate_error = !s_ok;
        memory_offset    = s_ok ? {s_sub, s_row, s_col} : '0;
      end
    endcase
  end

endmodule

// ===== rtl/ppe_entry_pack.sv =====
// Threshold and pedestal packing into the 12-bit pedestal memory entry.
`timescale 1ns / 1ps
module ppe_entry_pack (
  input  logic [ppe_pkg::MULT_W-1:0]         noise_multiplier,
  input  logic signed [ppe_pkg::LEVEL_W-1:0] pedestal_level,
  input  logic signed [ppe_pkg::LEVEL_W-1:0] noise_level,
  input  logic                               bad_pixel,
  output logic [ppe_pkg::ENTRY_W-1:0]        entry_word
);
  import ppe_pkg::*;

  localparam int PROD_W = LEVEL_W + MULT_W + 1;
  localparam int THR_W  = PROD_W - 12;

  logic signed [LEVEL_W-4-1:0] ped_int;
  logic signed [PROD_W-1:0]    prod;
  logic signed [THR_W-1:0]     thr_full;
  logic signed [5:0]           thr;

  always_comb begin
    // Truncate toward zero: round up negatives that have a fraction.
    ped_int = pedestal_level[LEVEL_W-1:4]
              + {{(LEVEL_W-5){1'b0}},
                 (pedestal_level[LEVEL_W-1] && (pedestal_level[3:0] != 4'd0))};

    prod = PROD_W'(noise_level) * $signed({1'b0, noise_multiplier});
    thr_full = prod[PROD_W-1:12]
               + {{(THR_W-1){1'b0}}, (prod[PROD_W-1] && (prod[11:0] != 12'd0))};

    if (thr_full > THR_W'(THR_MAX))      thr = 6'(THR_MAX);
    else if (thr_full < THR_W'(THR_MIN)) thr = 6'(THR_MIN);
    else                                 thr = thr_full[5:0];

    entry_word = bad_pixel ? MASK_WORD : {1'b0, ped_int[4:0], thr};
  end

endmodule

// ===== rtl/pixel_pedestal_entry_encoder_top.sv =====
// Top level of the pixel pedestal entry encoder: input and result registers.
`timescale 1ns / 1ps
// Pixel pedestal entry encoder. Each request carries one pixel record
// (column, row, pedestal, noise, bad flag) and yields one result: the
// pedestal memory word address, the 12-bit entry word and a coordinate error
// flag. The block takes one request every clock cycle while in_stall is low.
// An accepted request is held in the input register; its result is loaded
// into the result register when that register can advance, and it shows on
// the outputs there until it is taken. The single noise by multiplier product
// between those two registers sets the cycle time. With both registers full
// and the result stalled, in_stall rises in the same cycle; otherwise a new
// request is taken while a finished result still waits. Configuration is
// written through cfg_write_enable, cfg_index (0 = sensor type, 1 = noise
// multiplier) and cfg_data; the user must write it only while no request is
// in flight, as the block itself does not enforce it.
module pixel_pedestal_entry_encoder_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppe_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ppe_pkg::COL_W-1:0]           column,
  input  logic [ppe_pkg::ROW_W-1:0]           row,
  input  logic signed [ppe_pkg::LEVEL_W-1:0]  pedestal_level,
  input  logic signed [ppe_pkg::LEVEL_W-1:0]  noise_level,
  input  logic                                bad_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ppe_pkg::OFFSET_W-1:0]        memory_offset,
  output logic [ppe_pkg::ENTRY_W-1:0]         entry_word,
  output logic                                coordinate_error
);
  import ppe_pkg::*;

  cfg_t cfg;

  // Input register.
  logic                      s1_valid;
  logic [COL_W-1:0]          s1_column;
  logic [ROW_W-1:0]          s1_row;
  logic signed [LEVEL_W-1:0] s1_pedestal;
  logic signed [LEVEL_W-1:0] s1_noise;
  logic                      s1_bad;

  logic                      advance;
  logic [OFFSET_W-1:0]       offset_next;
  logic [ENTRY_W-1:0]        entry_next;
  logic                      error_next;

  ppe_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  // Advance the result register whenever it is empty or being taken;
  // hold the input register only when the result side cannot move.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_column   <= column;
      s1_row      <= row;
      s1_pedestal <= pedestal_level;
      s1_noise    <= noise_level;
      s1_bad      <= bad_pixel;
    end
  end

  ppe_addr_map u_map (
    .sensor_type      (cfg.sensor_type),
    .column           (s1_column),
    .row              (s1_row),
    .memory_offset    (offset_next),
    .coordinate_error (error_next)
  );

  ppe_entry_pack u_pack (
    .noise_multiplier (cfg.noise_multiplier),
    .pedestal_level   (s1_pedestal),
    .noise_level      (s1_noise),
    .bad_pixel        (s1_bad),
    .entry_word       (entry_next)
  );

  // Result register: drop the finished result in when allowed to advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      memory_offset    <= offset_next;
      entry_word       <= entry_next;
      coordinate_error <= error_next;
    end
  end

endmodule

// ===== rtl/ppe_checker.sv =====
// Port-level checker for the pixel pedestal entry encoder, with its bind.
`timescale 1ns / 1ps
module ppe_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [ppe_pkg::OFFSET_W-1:0]        memory_offset,
  input logic [ppe_pkg::ENTRY_W-1:0]         entry_word,
  input logic                                coordinate_error
);
  import ppe_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk)
    (!rst && out_valid && out_stall) |=>
      (rst || (out_valid && $stable(memory_offset) && $stable(entry_word)
               && $stable(coordinate_error))))
    else $error("stalled result changed");

  // Out-of-range coordinates give a zero address.
  a_error_zero: assert property (@(posedge clk)
    (!rst && out_valid && coordinate_error) |-> (memory_offset == '0))
    else $error("nonzero address with coordinate error");

  // Valid addresses always skip the dummy columns.
  a_dummy_cols: assert property (@(posedge clk)
    (!rst && out_valid && !coordinate_error) |-> (memory_offset[8:0] >= DUMMY_COLS))
    else $error("address falls in dummy columns");

  // The pedestal field never reaches bit 11 except in the masking word.
  a_entry_top: assert property (@(posedge clk)
    (!rst && out_valid && (entry_word != MASK_WORD)) |-> !entry_word[11])
    else $error("entry word top bit set outside masking word");

endmodule

bind pixel_pedestal_entry_encoder_top ppe_checker u_ppe_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the pixel pedestal entry encoder.
`timescale 1ns / 1ps
module tb;
  import ppe_pkg::*;

  // The worst case per request is a sender gap, a receiver hold and the two
  // register stages. The limit is set well above that.
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE_TICKS = 4;

  typedef struct {
    logic [OFFSET_W-1:0] offset;
    logic [ENTRY_W-1:0]  entry;
    logic                err;
  } pixel_result_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write_enable;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [COL_W-1:0]           column;
  logic [ROW_W-1:0]           row;
  logic signed [LEVEL_W-1:0]  pedestal_level;
  logic signed [LEVEL_W-1:0]  noise_level;
  logic                       bad_pixel;
  logic                       out_valid;
  logic                       out_stall;
  logic [OFFSET_W-1:0]        memory_offset;
  logic [ENTRY_W-1:0]         entry_word;
  logic                       coordinate_error;

  // Predictor copy of the configuration registers.
  sensor_t           cur_sensor;
  logic [MULT_W-1:0] cur_mult;

  pixel_result_t pending_entries[$];

  int  errors;
  int  cycles;
  int  records_sent;
  int  entries_checked;
  int  reg_writes;
  int  input_stall_cycles;
  bit  idle_on;
  int  long_hold_cycles;

  pixel_pedestal_entry_encoder_top DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .column           (column),
    .row              (row),
    .pedestal_level   (pedestal_level),
    .noise_level      (noise_level),
    .bad_pixel        (bad_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .memory_offset    (memory_offset),
    .entry_word       (entry_word),
    .coordinate_error (coordinate_error)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the memory address and packed entry for one pixel record under
  // the current sensor type and noise multiplier.
  function automatic pixel_result_t encode_pixel(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] rw,
                                                 input logic signed [LEVEL_W-1:0] ped,
                                                 input logic signed [LEVEL_W-1:0] noise,
                                                 input logic bad);
    pixel_result_t res;
    int unsigned   x;
    int unsigned   y;
    int unsigned   sub;
    int unsigned   qx;
    int unsigned   qy;
    int unsigned   addr;
    int            ped_int;
    longint        thr;
    x    = 32'(col);
    y    = 32'(rw);
    addr = 0;
    res.err = 1'b0;
    if (cur_sensor == SENSOR_SUBMATRIX) begin
      if (x >= 256 || y >= 256) begin
        res.err = 1'b1;
      end else begin
        // Submatrices 1 and 2 trade places in memory.
        sub = x >> 6;
        if (sub == 1 || sub == 2) sub = 3 - sub;
        addr = ((x & 63) + 2) | (y << 9) | (sub << 18);
      end
    end else begin
      if (x >= 508) begin
        res.err = 1'b1;
      end else begin
        // Quadrants 1 and 3 trade places, then mirror by quadrant.
        sub = x / 254 + 2 * (y / 256);
        if (sub == 1 || sub == 3) sub = 4 - sub;
        qx = x % 254;
        qy = y % 256;
        if (sub == 3) begin
          qx = 253 - qx;
        end else if (sub == 2) begin
          qy = 255 - qy;
        end else if (sub == 1) begin
          qx = 253 - qx;
          qy = 255 - qy;
        end
        addr = (qx + 2) | (qy << 9) | (sub << 18);
      end
    end
    res.offset = addr[OFFSET_W-1:0];

    if (bad) begin
      res.entry = MASK_WORD;
    end else begin
      // Both divisions truncate toward zero.
      ped_int = int'(ped) / 16;
      thr = (longint'(noise) * longint'(cur_mult)) / 4096;
      if (thr > THR_MAX) thr = longint'(THR_MAX);
      if (thr < THR_MIN) thr = longint'(THR_MIN);
      res.entry = {1'b0, ped_int[4:0], thr[5:0]};
    end
    return res;
  endfunction

  // Offer one pixel record, after a random gap when idle_on is set, and hold it until taken.
  task automatic send_request(input logic [COL_W-1:0] col,
                              input logic [ROW_W-1:0] rw,
                              input logic signed [LEVEL_W-1:0] ped,
                              input logic signed [LEVEL_W-1:0] noise,
                              input logic bad);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    column         <= col;
    row            <= rw;
    pedestal_level <= ped;
    noise_level    <= noise;
    bad_pixel      <= bad;
    do @(posedge clk); while (in_stall);
    pending_entries.push_back(encode_pixel(col, rw, ped, noise, bad));
    records_sent++;
  endtask

  // Drop valid and hold until every expected result has been checked.
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
  endtask

  // Write one register with the pipeline empty and settled.
  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    drain_requests();
    repeat (SETTLE_TICKS) @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value;
    @(posedge clk);
    case (idx)
      REG_SENSOR_TYPE: cur_sensor = sensor_t'(value[0]);
      REG_NOISE_MULT:  cur_mult   = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  // Upper data bits are don't-care for the sensor type; keep them random.
  task automatic set_sensor(input sensor_t kind);
    logic [CFG_DATA_W-1:0] value;
    value    = CFG_DATA_W'($urandom);
    value[0] = kind;
    write_register(REG_SENSOR_TYPE, value);
  endtask

  // One random record: mostly on-sensor coordinates, the rest off-sensor, and
  // mostly noise near the clamp window, the rest full range.
  task automatic send_random_pixel();
    logic [COL_W-1:0]          col;
    logic [ROW_W-1:0]          rw;
    logic signed [LEVEL_W-1:0] ped;
    logic signed [LEVEL_W-1:0] noise;
    logic                      bad;
    int                        target;
    longint                    n;
    if ($urandom_range(0, 99) < 88) begin
      if (cur_sensor == SENSOR_SUBMATRIX) begin
        col = COL_W'($urandom_range(0, 255));
        rw  = ROW_W'($urandom_range(0, 255));
      end else begin
        col = COL_W'($urandom_range(0, 507));
        rw  = ROW_W'($urandom_range(0, 511));
      end
    end else if (cur_sensor == SENSOR_SUBMATRIX) begin
      col = COL_W'($urandom_range(0, 511));
      rw  = ROW_W'($urandom_range(256, 511));
      if ($urandom_range(0, 1)) begin
        col = COL_W'($urandom_range(256, 511));
        rw  = ROW_W'($urandom_range(0, 511));
      end
    end else begin
      col = COL_W'($urandom_range(508, 511));
      rw  = ROW_W'($urandom_range(0, 511));
    end

    if ($urandom_range(0, 9) < 7) ped = LEVEL_W'($urandom);
    else ped = LEVEL_W'(int'($urandom_range(0, 1200)) - 600);

    if ($urandom_range(0, 2) == 0 || cur_mult == 0) begin
      noise = LEVEL_W'($urandom);
    end else begin
      target = int'($urandom_range(0, 80)) - 40;
      n = (longint'(target) * 4096) / longint'(cur_mult)
          + longint'(int'($urandom_range(0, 8)) - 4);
      if (n > 32767) n = 32767;
      if (n < -32768) n = -32768;
      noise = n[LEVEL_W-1:0];
    end

    bad = ($urandom_range(0, 7) == 0);
    send_request(col, rw, ped, noise, bad);
  endtask

  // Address corners of every submatrix, out of range coordinates, pedestal
  // and noise extremes, clamping both ways and the bad pixel mask.
  task automatic test_submatrix_corners();
    send_request(9'd0,   9'd0,   16'sd0,      16'sd0,      1'b0);
    send_request(9'd63,  9'd1,   -16'sd16,    16'sd255,    1'b0);
    send_request(9'd64,  9'd2,   16'sd15,     16'sd256,    1'b0);
    send_request(9'd127, 9'd254, -16'sd1,     -16'sd256,   1'b0);
    send_request(9'd128, 9'd255, 16'sd32767,  16'sd32767,  1'b0);
    send_request(9'd191, 9'd128, -16'sd32768, -16'sd32768, 1'b0);
    send_request(9'd192, 9'd200, 16'sh0AB0,   -16'sd9,     1'b0);
    send_request(9'd255, 9'd255, -16'sd32768, 16'sd32767,  1'b1);
    send_request(9'd256, 9'd0,   16'sd100,    16'sd40,     1'b0);
    send_request(9'd0,   9'd256, -16'sd100,   -16'sd40,    1'b0);
    send_request(9'd511, 9'd511, 16'sd32767,  -16'sd32768, 1'b1);
  endtask

  // Quadrant borders, the mirrored corners and columns past the last one.
  task automatic test_quadrant_corners();
    set_sensor(SENSOR_QUADRANT);
    send_request(9'd0,   9'd0,   16'sd496,    16'sd8,      1'b0);
    send_request(9'd253, 9'd0,   -16'sd496,   -16'sd8,     1'b0);
    send_request(9'd254, 9'd0,   16'sd32767,  16'sd300,    1'b0);
    send_request(9'd507, 9'd255, -16'sd32768, -16'sd300,   1'b0);
    send_request(9'd0,   9'd256, 16'sd31,     16'sd7,      1'b0);
    send_request(9'd253, 9'd511, -16'sd17,    -16'sd7,     1'b0);
    send_request(9'd254, 9'd256, 16'sd512,    16'sd32767,  1'b1);
    send_request(9'd507, 9'd511, -16'sd512,   -16'sd32768, 1'b0);
    send_request(9'd508, 9'd0,   16'sd1,      16'sd1,      1'b0);
    send_request(9'd511, 9'd511, -16'sd1,     -16'sd1,     1'b1);
  endtask

  // Random records under a series of settings, multiplier extremes included.
  task automatic test_config_sweep();
    sensor_t           kinds[8];
    logic [MULT_W-1:0] mults[8];
    kinds = '{SENSOR_SUBMATRIX, SENSOR_QUADRANT, SENSOR_SUBMATRIX, SENSOR_QUADRANT,
              SENSOR_SUBMATRIX, SENSOR_QUADRANT, SENSOR_SUBMATRIX, SENSOR_QUADRANT};
    mults = '{NOISE_MULT_RESET, NOISE_MULT_RESET, 16'd0, 16'hFFFF,
              16'hFFFF, 16'd1, 16'($urandom), 16'($urandom)};
    foreach (kinds[p]) begin
      set_sensor(kinds[p]);
      write_register(REG_NOISE_MULT, mults[p]);
      repeat (PHASE_ITEMS) send_random_pixel();
    end
  endtask

  // Full rate on both sides: no gaps, no stalls.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (100) send_random_pixel();
    idle_on = 1'b1;
  endtask

  // Hold off the result side for a long stretch while requests keep coming,
  // so the pipeline fills and pushes back; then pause until it empties.
  task automatic test_backpressure();
    idle_on = 1'b0;
    long_hold_cycles = 48;
    repeat (40) send_random_pixel();
    idle_on = 1'b1;
    drain_requests();
  endtask

  // Result side: draw a hold per result, take a long hold when asked.
  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    forever begin
      if (long_hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold_cycles) @(negedge clk);
        long_hold_cycles = 0;
      end
      wait_cycles = idle_on ? $urandom_range(0, 7) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_entries.size() == 0) begin
          $display("%0t: unexpected result: offset %h entry %h error %b", $time,
                   memory_offset, entry_word, coordinate_error);
          errors++;
        end else begin
          pixel_result_t want;
          want = pending_entries.pop_front();
          entries_checked++;
          if (memory_offset !== want.offset) begin
            $display("%0t: memory_offset mismatch: expected %h, got %h", $time,
                     want.offset, memory_offset);
            errors++;
          end
          if (entry_word !== want.entry) begin
            $display("%0t: entry_word mismatch: expected %h, got %h", $time,
                     want.entry, entry_word);
            errors++;
          end
          if (coordinate_error !== want.err) begin
            $display("%0t: coordinate_error mismatch: expected %b, got %b", $time,
                     want.err, coordinate_error);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a hang ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d results outstanding", $time,
               CYCLE_LIMIT, pending_entries.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    errors             = 0;
    cycles             = 0;
    records_sent       = 0;
    entries_checked    = 0;
    reg_writes         = 0;
    input_stall_cycles = 0;
    idle_on            = 1'b1;
    long_hold_cycles   = 0;
    cur_sensor         = SENSOR_SUBMATRIX;
    cur_mult           = NOISE_MULT_RESET;
    rst                = 1'b1;
    cfg_write_enable   = 1'b0;
    cfg_index          = REG_SENSOR_TYPE;
    cfg_data           = '0;
    in_valid           = 1'b0;
    column             = '0;
    row                = '0;
    pedestal_level     = '0;
    noise_level        = '0;
    bad_pixel          = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_submatrix_corners();
    test_quadrant_corners();
    test_config_sweep();
    test_back_to_back();
    test_backpressure();

    // Let any stray result show up before closing.
    drain_requests();
    repeat (8) @(posedge clk);

    $display("Checked %0d results from %0d pixel records over %0d register writes,",
             entries_checked, records_sent, reg_writes);
    $display("both sensor types, multiplier 0 to 0xFFFF; input held off on %0d cycles.",
             input_stall_cycles);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ppe_pkg.sv
rtl/ppe_cfg_regs.sv
rtl/ppe_addr_map.sv
rtl/ppe_entry_pack.sv
rtl/pixel_pedestal_entry_encoder_top.sv
rtl/ppe_checker.sv
dv/tb.sv
